/* src/kdf_pkg.sv */
// kdf_pkg: shared types, codes and helpers of the kdf object tlv parser
// no dependencies; used by the top level

package kdf_pkg;

  // default salt record length in bytes
  localparam int unsigned SALT_BYTES_DEF = 8;

  // record tags
  localparam logic [7:0] TAG_ALGO      = 8'h81;
  localparam logic [7:0] TAG_HASH      = 8'h82;
  localparam logic [7:0] TAG_ITER      = 8'h83;
  localparam logic [7:0] TAG_PW1_SALT  = 8'h84;
  localparam logic [7:0] TAG_RC_SALT   = 8'h85;
  localparam logic [7:0] TAG_PW3_SALT  = 8'h86;
  localparam logic [7:0] TAG_PW1_INIT  = 8'h87;
  localparam logic [7:0] TAG_PW3_INIT  = 8'h88;

  // fixed record lengths
  localparam logic [7:0] LEN_ONE       = 8'd1;
  localparam logic [7:0] LEN_ITER      = 8'd4;
  localparam logic [7:0] LEN_HASH_256  = 8'd32;
  localparam logic [7:0] LEN_HASH_512  = 8'd64;

  // parse status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_LEN  = 3'd1;
  localparam logic [2:0] ST_BAD_ALGO = 3'd2;
  localparam logic [2:0] ST_BAD_HASH = 3'd3;
  localparam logic [2:0] ST_BAD_HLEN = 3'd4;
  localparam logic [2:0] ST_BAD_TAG  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] CFG_ALGO_NONE   = 3'd0;
  localparam logic [2:0] CFG_ALGO_DERIVE = 3'd1;
  localparam logic [2:0] CFG_HASH_NONE   = 3'd2;
  localparam logic [2:0] CFG_HASH_SHA256 = 3'd3;
  localparam logic [2:0] CFG_HASH_SHA512 = 3'd4;

  // configuration reset values
  localparam logic [7:0] RST_ALGO_NONE   = 8'd0;
  localparam logic [7:0] RST_ALGO_DERIVE = 8'd3;
  localparam logic [7:0] RST_HASH_NONE   = 8'd0;
  localparam logic [7:0] RST_HASH_SHA256 = 8'd8;
  localparam logic [7:0] RST_HASH_SHA512 = 8'd10;

  // result kinds
  localparam logic RK_VALUE   = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_VAL
  } phase_e;

  // one buffered output entry: an optional value byte and an optional summary
  typedef struct packed {
    logic        has_val;
    logic        has_sum;
    logic [2:0]  slot;
    logic [5:0]  offset;
    logic [7:0]  data;
    logic [2:0]  status;
    logic [7:0]  algo;
    logic [7:0]  hash;
    logic [31:0] iter;
    logic [4:0]  mask;
    logic [6:0]  pw1_len;
    logic [6:0]  pw3_len;
  } res_entry_t;

  // error decided once tag and length are known
  function automatic logic [2:0] header_error(logic [7:0] tag, logic [7:0] len,
                                              logic [7:0] salt_len);
    logic [2:0] err;
    case (tag)
      TAG_ALGO, TAG_HASH: begin
        err = (len == LEN_ONE) ? ST_OK : ST_BAD_LEN;
      end
      TAG_ITER: begin
        err = (len == LEN_ITER) ? ST_OK : ST_BAD_LEN;
      end
      TAG_PW1_SALT, TAG_RC_SALT, TAG_PW3_SALT: begin
        err = (len == salt_len) ? ST_OK : ST_BAD_LEN;
      end
      TAG_PW1_INIT, TAG_PW3_INIT: begin
        err = (len == LEN_HASH_256 || len == LEN_HASH_512) ? ST_OK : ST_BAD_HLEN;
      end
      default: begin
        err = ST_BAD_TAG;
      end
    endcase
    return err;
  endfunction

endpackage

/* src/kdf_ifs.sv */
// kdf_in_if / kdf_out_if: valid-ready channels of the kdf object tlv parser
// no dependencies

interface kdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       carries_byte;
  logic       ends_object;

  modport source (output valid, data_byte, carries_byte, ends_object, input ready);
  modport sink   (input valid, data_byte, carries_byte, ends_object, output ready);
endinterface

interface kdf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [2:0]  value_slot;
  logic [5:0]  value_offset;
  logic [7:0]  value_data;
  logic [2:0]  parse_status;
  logic [7:0]  algo_code;
  logic [7:0]  hash_code;
  logic [31:0] iterations;
  logic [4:0]  present_mask;
  logic [6:0]  pw1_hash_len;
  logic [6:0]  pw3_hash_len;
  logic        last_of_run;

  modport source (output valid, result_kind, value_slot, value_offset, value_data,
                  parse_status, algo_code, hash_code, iterations, present_mask,
                  pw1_hash_len, pw3_hash_len, last_of_run, input ready);
  modport sink   (input valid, result_kind, value_slot, value_offset, value_data,
                  parse_status, algo_code, hash_code, iterations, present_mask,
                  pw1_hash_len, pw3_hash_len, last_of_run, output ready);
endinterface

/* src/kdf_object_tlv_parser.sv */
// kdf_object_tlv_parser: byte-serial tlv parser for a kdf data object
// results: each input transfer's results are registered in the result buffer before they are offered
// throughput: one input transfer per cycle while the result buffer is not full; an item
//   that yields a value byte and a summary holds the output for two transfers (value, then summary)
// reset: asynchronous active low; parser state clears, config registers reload
// depends on kdf_pkg, kdf_in_if, kdf_out_if

module kdf_object_tlv_parser import kdf_pkg::*; #(
  parameter int unsigned SALT_BYTES = SALT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  kdf_in_if.sink     in_i,
  kdf_out_if.source  out_o
);

  localparam logic [7:0] SaltLen = 8'(SALT_BYTES);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] algo_none_q, algo_derive_q;
  logic [7:0] hash_none_q, hash_sha256_q, hash_sha512_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      algo_none_q   <= RST_ALGO_NONE;
      algo_derive_q <= RST_ALGO_DERIVE;
      hash_none_q   <= RST_HASH_NONE;
      hash_sha256_q <= RST_HASH_SHA256;
      hash_sha512_q <= RST_HASH_SHA512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALGO_NONE:   algo_none_q   <= cfg_data_i;
        CFG_ALGO_DERIVE: algo_derive_q <= cfg_data_i;
        CFG_HASH_NONE:   hash_none_q   <= cfg_data_i;
        CFG_HASH_SHA256: hash_sha256_q <= cfg_data_i;
        CFG_HASH_SHA512: hash_sha512_q <= cfg_data_i;
        default: ; // writes beyond the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // parser state
  // ---------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  rem_q, rem_d;         // value bytes still to come
  logic [6:0]  off_q, off_d;         // offset within value, at most 64 on valid records
  logic [2:0]  pend_q, pend_d;       // error from the header, held until record end
  logic [2:0]  commit_q, commit_d;   // first committed error, freezes decoding
  logic [7:0]  first_q, first_d;
  logic [31:0] shift_q, shift_d;
  logic [7:0]  algo_q, algo_d;
  logic [7:0]  hash_q, hash_d;
  logic [31:0] iter_q, iter_d;
  logic [4:0]  mask_q, mask_d;
  logic [6:0]  pw1_len_q, pw1_len_d;
  logic [6:0]  pw3_len_q, pw3_len_d;

  // output buffer control
  res_entry_t  ent_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        sub_q;                // value half of a two-result entry already sent

  logic        in_fire, out_fire;
  logic        step;
  logic        finish;
  logic        emit_val;
  logic        push, pop;
  logic [7:0]  tag_rel;
  logic        hash_ok;
  res_entry_t  new_ent;

  assign in_i.ready = (cnt_q != 2'd2);
  assign in_fire    = in_i.valid & in_i.ready;
  assign step       = in_fire & in_i.carries_byte & (commit_q == ST_OK);
  assign tag_rel    = tag_q - TAG_PW1_SALT;

  // ---------------------------------------------------------------------------
  // next state of the parser and the entry built for this transfer
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    rem_d     = rem_q;
    off_d     = off_q;
    pend_d    = pend_q;
    commit_d  = commit_q;
    first_d   = first_q;
    shift_d   = shift_q;
    algo_d    = algo_q;
    hash_d    = hash_q;
    iter_d    = iter_q;
    mask_d    = mask_q;
    pw1_len_d = pw1_len_q;
    pw3_len_d = pw3_len_q;
    finish    = 1'b0;
    emit_val  = 1'b0;
    hash_ok   = 1'b0;
    new_ent   = '0;

    if (step) begin
      case (phase_q)
        PH_TAG: begin
          tag_d   = in_i.data_byte;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          rem_d   = in_i.data_byte;
          off_d   = '0;
          shift_d = '0;
          first_d = '0;
          pend_d  = header_error(tag_q, in_i.data_byte, SaltLen);
          if (in_i.data_byte == 8'd0) begin
            finish = 1'b1;
          end else begin
            phase_d = PH_VAL;
          end
        end
        PH_VAL: begin
          if (off_q == 7'd0) begin
            first_d = in_i.data_byte;
          end
          shift_d = {shift_q[23:0], in_i.data_byte};
          // salt and initial-hash bytes of good records go straight out
          if (pend_q == ST_OK && tag_q >= TAG_PW1_SALT && tag_q <= TAG_PW3_INIT) begin
            emit_val       = 1'b1;
            new_ent.slot   = tag_rel[2:0];
            new_ent.offset = off_q[5:0];
            new_ent.data   = in_i.data_byte;
          end
          off_d = off_q + 7'd1;
          rem_d = rem_q - 8'd1;
          if (rem_q == 8'd1) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
    end

    // record complete: commit its error or take over its content
    if (finish) begin
      phase_d = PH_TAG;
      hash_ok = (first_d == hash_none_q) || (first_d == hash_sha256_q) ||
                (first_d == hash_sha512_q);
      if (pend_d != ST_OK) begin
        commit_d = pend_d;
      end else begin
        case (tag_q)
          TAG_ALGO: begin
            if (first_d != algo_none_q && first_d != algo_derive_q) begin
              commit_d = ST_BAD_ALGO;
            end else begin
              algo_d = first_d;
            end
          end
          TAG_HASH: begin
            if (!hash_ok) begin
              commit_d = ST_BAD_HASH;
            end else begin
              hash_d = first_d;
            end
          end
          TAG_ITER:     iter_d = shift_d;
          TAG_PW1_SALT: mask_d = mask_q | 5'b00001;
          TAG_RC_SALT:  mask_d = mask_q | 5'b00010;
          TAG_PW3_SALT: mask_d = mask_q | 5'b00100;
          TAG_PW1_INIT: begin
            mask_d    = mask_q | 5'b01000;
            pw1_len_d = off_d;
          end
          TAG_PW3_INIT: begin
            mask_d    = mask_q | 5'b10000;
            pw3_len_d = off_d;
          end
          default: commit_d = ST_BAD_TAG;
        endcase
      end
    end

    new_ent.has_val = emit_val;

    // end of object: summary from the updated state, then everything clears
    if (in_fire && in_i.ends_object) begin
      new_ent.has_sum = 1'b1;
      if (commit_d != ST_OK) begin
        new_ent.status = commit_d;
      end else if (phase_d != PH_TAG) begin
        new_ent.status = ST_BAD_LEN; // object cut inside a record
      end else begin
        new_ent.status = ST_OK;
      end
      new_ent.algo    = algo_d;
      new_ent.hash    = hash_d;
      new_ent.iter    = iter_d;
      new_ent.mask    = mask_d;
      new_ent.pw1_len = pw1_len_d;
      new_ent.pw3_len = pw3_len_d;

      phase_d   = PH_TAG;
      tag_d     = '0;
      rem_d     = '0;
      off_d     = '0;
      pend_d    = ST_OK;
      commit_d  = ST_OK;
      first_d   = '0;
      shift_d   = '0;
      algo_d    = '0;
      hash_d    = '0;
      iter_d    = '0;
      mask_d    = '0;
      pw1_len_d = '0;
      pw3_len_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TAG;
      tag_q     <= '0;
      rem_q     <= '0;
      off_q     <= '0;
      pend_q    <= ST_OK;
      commit_q  <= ST_OK;
      first_q   <= '0;
      shift_q   <= '0;
      algo_q    <= '0;
      hash_q    <= '0;
      iter_q    <= '0;
      mask_q    <= '0;
      pw1_len_q <= '0;
      pw3_len_q <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      tag_q     <= tag_d;
      rem_q     <= rem_d;
      off_q     <= off_d;
      pend_q    <= pend_d;
      commit_q  <= commit_d;
      first_q   <= first_d;
      shift_q   <= shift_d;
      algo_q    <= algo_d;
      hash_q    <= hash_d;
      iter_q    <= iter_d;
      mask_q    <= mask_d;
      pw1_len_q <= pw1_len_d;
      pw3_len_q <= pw3_len_d;
    end
  end

  // ---------------------------------------------------------------------------
  // two-entry result buffer; one entry per transfer that yields any result
  // ---------------------------------------------------------------------------
  res_entry_t head;
  logic       head_two;
  logic       head_last;

  assign head      = ent_q[rd_ptr_q];
  assign head_two  = head.has_val & head.has_sum;
  assign head_last = ~(head_two & ~sub_q);
  assign out_fire  = out_o.valid & out_o.ready;
  assign push      = in_fire & (emit_val | in_i.ends_object);
  assign pop       = out_fire & head_last;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
      if (out_fire) begin
        sub_q <= ~head_last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output mux: value half first, then summary half
  // ---------------------------------------------------------------------------
  logic show_val;

  assign show_val = head.has_val & ~sub_q;

  always_comb begin
    out_o.valid        = (cnt_q != 2'd0);
    out_o.last_of_run  = head_last;
    out_o.result_kind  = show_val ? RK_VALUE : RK_SUMMARY;
    out_o.value_slot   = '0;
    out_o.value_offset = '0;
    out_o.value_data   = '0;
    out_o.parse_status = ST_OK;
    out_o.algo_code    = '0;
    out_o.hash_code    = '0;
    out_o.iterations   = '0;
    out_o.present_mask = '0;
    out_o.pw1_hash_len = '0;
    out_o.pw3_hash_len = '0;
    if (show_val) begin
      out_o.value_slot   = head.slot;
      out_o.value_offset = head.offset;
      out_o.value_data   = head.data;
    end else begin
      out_o.parse_status = head.status;
      out_o.algo_code    = head.algo;
      out_o.hash_code    = head.hash;
      out_o.iterations   = head.iter;
      out_o.present_mask = head.mask;
      out_o.pw1_hash_len = head.pw1_len;
      out_o.pw3_hash_len = head.pw3_len;
    end
  end

endmodule
